### src/serial_command_token_framer_defines.svh
// Assertion macros used by the framer checker.
`ifndef SERIAL_COMMAND_TOKEN_FRAMER_DEFINES_SVH
`define SERIAL_COMMAND_TOKEN_FRAMER_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define SCF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define SCF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### src/scf_pkg.sv
// Package: types, token constants and the tail match function of the token framer.
package scf_pkg;

  localparam int WIN_LEN          = 8;
  localparam int BYTE_W           = 8;
  localparam int FILL_W           = 4;
  localparam int CFG_IDX_W        = 2;
  localparam int PAYLOAD_CAP_DEF  = 512;

  typedef logic [0:WIN_LEN-1][BYTE_W-1:0] win_t;

  // Tokens are right-aligned: the last character sits in the newest slot.
  localparam win_t TOK_READY  = {8'h00, ":READY:"};
  localparam win_t TOK_FINISH = ":FINISH:";
  localparam win_t TOK_RESET  = {8'h00, ":RESET:"};
  localparam win_t TOK_ON     = {32'h0, ":ON:"};
  localparam win_t TOK_OFF    = {24'h0, ":OFF:"};

  localparam logic [FILL_W-1:0] LEN_READY  = 4'd7;
  localparam logic [FILL_W-1:0] LEN_FINISH = 4'd8;
  localparam logic [FILL_W-1:0] LEN_RESET  = 4'd7;
  localparam logic [FILL_W-1:0] LEN_ON     = 4'd4;
  localparam logic [FILL_W-1:0] LEN_OFF    = 4'd5;
  localparam logic [FILL_W-1:0] FILL_FULL  = 4'd8;

  localparam logic [CFG_IDX_W-1:0] REG_ON_BRIGHTNESS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_BRIGHTNESS = 2'd1;

  localparam logic [BYTE_W-1:0] ON_BRIGHTNESS_RST  = 8'd5;
  localparam logic [BYTE_W-1:0] OFF_BRIGHTNESS_RST = 8'd0;

  typedef enum logic [1:0] {
    REPLY_NONE     = 2'd0,
    REPLY_OK       = 2'd1,
    REPLY_RECEIVED = 2'd2
  } reply_t;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_COMPLETE = 2'd1,
    EV_ABORT    = 2'd2,
    EV_OVERFLOW = 2'd3
  } frame_ev_t;

  typedef enum logic {
    MODE_WAIT    = 1'b0,
    MODE_RECEIVE = 1'b1
  } mode_t;

  // Control handed from the sequencer to every window cell.
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  // True when the newest len bytes of w equal the token and len bytes have arrived.
  function automatic logic tail_is(input win_t w, input win_t tok,
                                   input logic [FILL_W-1:0] len,
                                   input logic [FILL_W-1:0] fill);
    logic ok;
    ok = (fill >= len);
    for (int k = 0; k < WIN_LEN; k++) begin
      if ((k >= WIN_LEN - int'(len)) && (w[k] != tok[k])) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

### src/scf_cell.sv
// One byte slot of the tail window; takes its d_in byte on every shift unless cleared.
module scf_cell (
  input  logic                          clk,
  input  scf_pkg::cell_ctl_t            ctl,
  input  logic [scf_pkg::BYTE_W-1:0]    d_in,
  output logic [scf_pkg::BYTE_W-1:0]    q
);
  import scf_pkg::*;

  logic [BYTE_W-1:0] q_r;

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      q_r <= '0;
    end else if (ctl.shift) begin
      q_r <= d_in;
    end
  end

  assign q = q_r;

endmodule

### src/scf_ctrl.sv
// Token matcher, frame sequencer, counters, config registers and output register.
module scf_ctrl #(
  parameter int PAYLOAD_CAPACITY = scf_pkg::PAYLOAD_CAP_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [scf_pkg::BYTE_W-1:0]     in_rx_byte,
  input  scf_pkg::win_t                  win,
  output scf_pkg::cell_ctl_t             cell_ctl,
  input  logic                           cfg_we,
  input  logic [scf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [scf_pkg::BYTE_W-1:0]     cfg_wdata,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_payload_valid,
  output logic [scf_pkg::BYTE_W-1:0]     out_payload_byte,
  output logic [1:0]                     out_reply_code,
  output logic [1:0]                     out_frame_event,
  output logic                           out_display_valid,
  output logic                           out_display_on,
  output logic [scf_pkg::BYTE_W-1:0]     out_brightness_level
);
  import scf_pkg::*;

  localparam int PC_W = $clog2(PAYLOAD_CAPACITY);
  localparam logic [PC_W:0] CAP = (PC_W + 1)'(PAYLOAD_CAPACITY);

  mode_t             mode_r, mode_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt, fill_a;
  logic [PC_W-1:0]   pc_r, pc_nxt, pc_inc;
  logic [BYTE_W-1:0] on_bri_r, off_bri_r;

  logic              out_valid_r, out_valid_nxt;
  logic              pv_r, pv_nxt;
  logic [BYTE_W-1:0] pb_r, pb_nxt;
  reply_t            reply_r, reply_nxt;
  frame_ev_t         ev_r, ev_nxt;
  logic              dv_r, dv_nxt;
  logic              don_r, don_nxt;
  logic [BYTE_W-1:0] bl_r, bl_nxt;

  logic              acc;
  win_t              win_sh;
  logic              m_reset, m_on, m_off, m_finish, m_ready, cmd, clr;
  logic [PC_W:0]     frame_sum;

  assign in_ready = !out_valid_r || out_ready;
  assign acc      = in_valid && in_ready;

  always_comb begin
    for (int j = 0; j < WIN_LEN - 1; j++) begin
      win_sh[j] = win[j+1];
    end
    win_sh[WIN_LEN-1] = in_rx_byte;
  end

  assign fill_a    = (fill_r == FILL_FULL) ? FILL_FULL : fill_r + 4'd1;
  assign m_reset   = tail_is(win_sh, TOK_RESET,  LEN_RESET,  fill_a);
  assign m_on      = tail_is(win_sh, TOK_ON,     LEN_ON,     fill_a);
  assign m_off     = tail_is(win_sh, TOK_OFF,    LEN_OFF,    fill_a);
  assign m_finish  = tail_is(win_sh, TOK_FINISH, LEN_FINISH, fill_a);
  assign m_ready   = tail_is(win_sh, TOK_READY,  LEN_READY,  fill_a);
  assign cmd       = m_reset || m_on || m_off;

  assign pv_nxt    = (mode_r == MODE_RECEIVE) && (fill_r == FILL_FULL);
  assign pc_inc    = pc_r + PC_W'(pv_nxt);
  assign frame_sum = {1'b0, pc_inc} + (PC_W + 1)'(fill_a);

  always_comb begin
    mode_nxt  = mode_r;
    reply_nxt = REPLY_NONE;
    ev_nxt    = EV_NONE;
    dv_nxt    = 1'b0;
    don_nxt   = 1'b0;
    bl_nxt    = '0;
    clr       = 1'b0;
    pb_nxt    = pv_nxt ? win[0] : '0;

    if (m_reset) begin
      dv_nxt = 1'b0;
    end else if (m_on) begin
      dv_nxt  = 1'b1;
      don_nxt = 1'b1;
      bl_nxt  = on_bri_r;
    end else if (m_off) begin
      dv_nxt  = 1'b1;
      bl_nxt  = off_bri_r;
    end

    if (cmd) begin
      reply_nxt = REPLY_OK;
      ev_nxt    = (mode_r == MODE_RECEIVE) ? EV_ABORT : EV_NONE;
      mode_nxt  = MODE_WAIT;
      clr       = 1'b1;
    end else if (mode_r == MODE_RECEIVE) begin
      if (m_finish) begin
        reply_nxt = REPLY_RECEIVED;
        ev_nxt    = EV_COMPLETE;
        mode_nxt  = MODE_WAIT;
        clr       = 1'b1;
      end else if (frame_sum >= CAP) begin
        ev_nxt    = EV_OVERFLOW;
        mode_nxt  = MODE_WAIT;
        clr       = 1'b1;
      end
    end else if (m_ready) begin
      reply_nxt = REPLY_OK;
      mode_nxt  = MODE_RECEIVE;
      clr       = 1'b1;
    end

    fill_nxt = clr ? '0 : fill_a;
    pc_nxt   = clr ? '0 : pc_inc;

    if (acc) begin
      out_valid_nxt = pv_nxt || (reply_nxt != REPLY_NONE) || (ev_nxt != EV_NONE) || dv_nxt;
    end else begin
      out_valid_nxt = out_valid_r && !out_ready;
    end
  end

  assign cell_ctl.shift = acc;
  assign cell_ctl.clear = acc && clr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_WAIT;
      fill_r      <= '0;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (acc) begin
        mode_r <= mode_nxt;
        fill_r <= fill_nxt;
        pc_r   <= pc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_bri_r  <= ON_BRIGHTNESS_RST;
      off_bri_r <= OFF_BRIGHTNESS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ON_BRIGHTNESS:  on_bri_r  <= cfg_wdata;
        REG_OFF_BRIGHTNESS: off_bri_r <= cfg_wdata;
        default:            ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      pv_r    <= pv_nxt;
      pb_r    <= pb_nxt;
      reply_r <= reply_nxt;
      ev_r    <= ev_nxt;
      dv_r    <= dv_nxt;
      don_r   <= don_nxt;
      bl_r    <= bl_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_payload_valid    = pv_r;
  assign out_payload_byte     = pb_r;
  assign out_reply_code       = reply_r;
  assign out_frame_event      = ev_r;
  assign out_display_valid    = dv_r;
  assign out_display_on       = don_r;
  assign out_brightness_level = bl_r;

endmodule

### src/serial_command_token_framer.sv
// Top level of the serial command token framer: window cell row plus sequencer.
//
// Input channel (in_valid/in_ready/in_rx_byte): one received serial byte per
//   transaction. Output channel (out_valid/out_ready/out_*): at most one result
//   per byte, given only when a payload byte, reply, frame event or display
//   command is due; bytes that cause nothing produce no transaction.
// Config port (cfg_we/cfg_index/cfg_wdata): index 0 on brightness, index 1 off
//   brightness, taken on any edge with cfg_we high outside reset; other indexes are dropped.
// The last eight bytes sit in a row of eight byte cells that shift on every
//   accepted byte; token compares run in parallel on the shifted view.
// A result is registered and shows on the output in the cycle after its byte is accepted.
// Throughput: one byte per cycle, set by the single output register, which
//   accepts a new byte whenever it is empty or being drained that same cycle.
// Stall: while out_valid is high and out_ready low, hold the result and drop
//   in_ready; nothing is lost or repeated.
// Reset (rst_n low, synchronous): return to wait mode, clear fill and payload
//   counts, empty the output register, and load brightness defaults 5 and 0.
//   No clearing pass is needed; the block accepts bytes right after reset.
module serial_command_token_framer #(
  parameter int PAYLOAD_CAPACITY = scf_pkg::PAYLOAD_CAP_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [scf_pkg::BYTE_W-1:0]     in_rx_byte,
  input  logic                           cfg_we,
  input  logic [scf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [scf_pkg::BYTE_W-1:0]     cfg_wdata,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_payload_valid,
  output logic [scf_pkg::BYTE_W-1:0]     out_payload_byte,
  output logic [1:0]                     out_reply_code,
  output logic [1:0]                     out_frame_event,
  output logic                           out_display_valid,
  output logic                           out_display_on,
  output logic [scf_pkg::BYTE_W-1:0]     out_brightness_level
);
  import scf_pkg::*;

  // Window contents: slot 0 oldest, last slot newest.
  win_t      win;
  cell_ctl_t cell_ctl;

  // Cell row: each cell takes its newer neighbor's byte; the newest takes the input.
  for (genvar i = 0; i < WIN_LEN; i++) begin : g_cell
    logic [BYTE_W-1:0] d_in;
    if (i == WIN_LEN - 1) begin : g_head
      assign d_in = in_rx_byte;
    end else begin : g_body
      assign d_in = win[i+1];
    end
    scf_cell u_cell (
      .clk  (clk),
      .ctl  (cell_ctl),
      .d_in (d_in),
      .q    (win[i])
    );
  end

  // Sequencer: match tokens, advance mode and counters, drive the result register.
  scf_ctrl #(
    .PAYLOAD_CAPACITY (PAYLOAD_CAPACITY)
  ) u_ctrl (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_rx_byte           (in_rx_byte),
    .win                  (win),
    .cell_ctl             (cell_ctl),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_payload_valid    (out_payload_valid),
    .out_payload_byte     (out_payload_byte),
    .out_reply_code       (out_reply_code),
    .out_frame_event      (out_frame_event),
    .out_display_valid    (out_display_valid),
    .out_display_on       (out_display_on),
    .out_brightness_level (out_brightness_level)
  );

endmodule

### src/scf_checker.sv
// Port-level checker for the token framer and its bind.
`include "serial_command_token_framer_defines.svh"

module scf_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           out_payload_valid,
  input logic [scf_pkg::BYTE_W-1:0]     out_payload_byte,
  input logic [1:0]                     out_reply_code,
  input logic [1:0]                     out_frame_event,
  input logic                           out_display_valid,
  input logic                           out_display_on,
  input logic [scf_pkg::BYTE_W-1:0]     out_brightness_level
);
  import scf_pkg::*;

  `SCF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "stalled result dropped")
  `SCF_ASSERT_NOW(a_nonempty, out_valid, out_payload_valid || (out_reply_code != REPLY_NONE) || (out_frame_event != EV_NONE) || out_display_valid, "empty result transaction")
  `SCF_ASSERT_NOW(a_payload_zero, out_valid && !out_payload_valid, out_payload_byte == '0, "payload byte set without payload")
  `SCF_ASSERT_NOW(a_display_ok, out_valid && out_display_valid, out_reply_code == REPLY_OK, "display command without OK reply")
  `SCF_ASSERT_NOW(a_display_zero, out_valid && !out_display_valid, !out_display_on && (out_brightness_level == '0), "display fields set without command")

endmodule

bind serial_command_token_framer scf_checker u_scf_checker (.*);
